FILE: rtl/keyed_record_table_top_assert.svh
// ----------------------------------------------------------------------------
// keyed_record_table_top assertion macros
// Shorthand for clocked concurrent assertions that are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_TOP_ASSERT_SVH
`define KEYED_RECORD_TABLE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KRT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed_record_table_top: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define KRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed_record_table_top: next-cycle check failed");

`endif

FILE: rtl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and command codes of the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

	localparam int DEF_SLOTS = 64;
	localparam int KEY_W     = 56;
	localparam int PAY_W     = 64;
	localparam int MODE_W    = 3;
	localparam int RPOS_W    = 6;

	// Command codes carried by the mode field.
	localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_UPD1   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_UPD2   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

	// One stored record as it sits in the memory.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] p1;
		logic [PAY_W-1:0] p2;
	} krt_rec_t;

endpackage

FILE: rtl/krt_mem.sv
// ----------------------------------------------------------------------------
// krt_mem
// Record memory with one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module krt_mem
	import krt_pkg::*;
#(
	parameter int DEPTH = DEF_SLOTS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  krt_rec_t      wr_data,
	input  logic [AW-1:0] rd_addr,
	output krt_rec_t      rd_data
);

	krt_rec_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, read data registered.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/keyed_record_table_top.sv
// ----------------------------------------------------------------------------
// keyed_record_table_top
// Compacted table of keyed records held in one memory, with a sequencer that
// walks the entries one per cycle for search, delete and updates; reads go direct.
// ----------------------------------------------------------------------------
// Add and unused modes go straight to the result state; a read passes a read state;
// search, delete and updates scan from position 1 to the match or past the count.
// Delete then shifts each later record down by one position.
// One command is in work at a time; a new command is taken only when idle.
// A result word that is not taken holds the sequencer until the output frees.
// Reset clears the count and all control state; memory contents stay as is.
// ----------------------------------------------------------------------------
`include "keyed_record_table_top_assert.svh"

module keyed_record_table_top
	import krt_pkg::*;
#(
	parameter int SLOTS = DEF_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] mode,
	input  logic [KEY_W-1:0]  record_key,
	input  logic [PAY_W-1:0]  first_payload,
	input  logic [PAY_W-1:0]  second_payload,
	input  logic [RPOS_W-1:0] read_position,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              success,
	output logic [RPOS_W-1:0] found_position,
	output logic [KEY_W-1:0]  out_key,
	output logic [PAY_W-1:0]  out_first_payload,
	output logic [PAY_W-1:0]  out_second_payload,
	output logic [RPOS_W-1:0] entry_count
);

	localparam int PW = $clog2(SLOTS);
	localparam int WW = (PW + 1 > RPOS_W) ? PW + 1 : RPOS_W;
	localparam logic [PW-1:0] CNT_MAX = PW'(SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_READ  = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t        state_q;
	logic [PW-1:0] count_q;
	logic [PW:0]   idx_q;
	logic [PW:0]   j_q;
	logic          chk_vld_s1;
	logic [PW:0]   addr_s1;
	logic          sh_vld_s1;
	logic [PW:0]   sh_addr_s1;
	logic          out_valid_q;

	// Latched command word.
	logic [MODE_W-1:0] cmd_mode_q;
	logic [KEY_W-1:0]  cmd_key_q;
	logic [PAY_W-1:0]  cmd_p1_q;
	logic [PAY_W-1:0]  cmd_p2_q;
	logic [RPOS_W-1:0] cmd_rpos_q;

	// Pending result and output word.
	logic              res_ok_q;
	logic [RPOS_W-1:0] res_fpos_q;
	krt_rec_t          res_rec_q;
	logic              out_ok_q;
	logic [RPOS_W-1:0] out_fpos_q;
	krt_rec_t          out_rec_q;
	logic [RPOS_W-1:0] out_cnt_q;

	logic          accept;
	logic          out_free;
	logic [PW:0]   count_x;
	logic          add_ok;
	logic          scan_hit;
	logic          scan_miss;
	logic          scan_issue;
	logic          sh_issue;
	logic          sh_end;
	logic          is_upd;
	logic          rpos_ok;
	logic [WW-1:0] rpos_w;
	logic [WW-1:0] cnt_w;
	logic [WW-1:0] hit_w;
	logic [WW-1:0] cur_cnt_w;

	logic          mem_wr_en;
	logic [PW-1:0] mem_wr_addr;
	krt_rec_t      mem_wr_data;
	logic [PW-1:0] mem_rd_addr;
	krt_rec_t      mem_rd_data;

	// Handshake and sequencer conditions.
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign count_x    = {1'b0, count_q};
	assign add_ok     = accept && (mode == MODE_ADD) && (count_q < CNT_MAX);
	assign is_upd     = (cmd_mode_q == MODE_UPD1) || (cmd_mode_q == MODE_UPD2);
	assign scan_hit   = (state_q == ST_SCAN) && chk_vld_s1 && (mem_rd_data.key == cmd_key_q);
	assign scan_miss  = (state_q == ST_SCAN) && !chk_vld_s1 && (idx_q > count_x);
	assign scan_issue = (state_q == ST_SCAN) && !scan_hit && (idx_q <= count_x);
	assign sh_issue   = (state_q == ST_SHIFT) && (j_q <= count_x);
	assign sh_end     = (state_q == ST_SHIFT) && !sh_vld_s1 && !sh_issue;

	// Position conversions between the table width and the six-bit fields.
	assign rpos_w    = WW'(read_position);
	assign cnt_w     = WW'(count_q);
	assign hit_w     = WW'(addr_s1);
	assign cur_cnt_w = WW'(cmd_rpos_q);
	assign rpos_ok   = (cmd_rpos_q != '0) && (cur_cnt_w <= cnt_w);

	// Memory read address: the requested position, the scan or the shift.
	always_comb begin
		case (state_q)
			ST_SCAN:  mem_rd_addr = idx_q[PW-1:0];
			ST_SHIFT: mem_rd_addr = j_q[PW-1:0];
			default:  mem_rd_addr = rpos_w[PW-1:0];
		endcase
	end

	// Memory write port: append, payload update or shift down by one.
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_data = mem_rd_data;
		if (add_ok) begin
			mem_wr_en       = 1'b1;
			mem_wr_addr     = count_q + 1'b1;
			mem_wr_data.key = record_key;
			mem_wr_data.p1  = first_payload;
			mem_wr_data.p2  = second_payload;
		end else if (scan_hit && is_upd) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = addr_s1[PW-1:0];
			if (cmd_mode_q == MODE_UPD1) begin
				mem_wr_data.p1 = cmd_p1_q;
			end else begin
				mem_wr_data.p2 = cmd_p2_q;
			end
		end else if ((state_q == ST_SHIFT) && sh_vld_s1) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = PW'(sh_addr_s1 - 1'b1);
		end
	end

	krt_mem #(
		.DEPTH (SLOTS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Sequencer, count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			j_q         <= '0;
			chk_vld_s1  <= 1'b0;
			addr_s1     <= '0;
			sh_vld_s1   <= 1'b0;
			sh_addr_s1  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q      <= {{PW{1'b0}}, 1'b1};
						chk_vld_s1 <= 1'b0;
						case (mode)
							MODE_ADD: begin
								if (add_ok) begin
									count_q <= count_q + 1'b1;
								end
								state_q <= ST_FIN;
							end
							MODE_SEARCH, MODE_DELETE, MODE_UPD1, MODE_UPD2: begin
								state_q <= ST_SCAN;
							end
							MODE_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// No new read is issued on a hit, so the compare stage empties.
					chk_vld_s1 <= scan_issue;
					addr_s1    <= idx_q;
					if (scan_issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (scan_hit) begin
						if (cmd_mode_q == MODE_DELETE) begin
							j_q       <= addr_s1 + 1'b1;
							sh_vld_s1 <= 1'b0;
							state_q   <= ST_SHIFT;
						end else begin
							state_q <= ST_FIN;
						end
					end else if (scan_miss) begin
						state_q <= ST_FIN;
					end
				end
				ST_SHIFT: begin
					sh_vld_s1  <= sh_issue;
					sh_addr_s1 <= j_q;
					if (sh_issue) begin
						j_q <= j_q + 1'b1;
					end
					if (sh_end) begin
						count_q <= count_q - 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_READ: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command word, pending result and output word.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_mode_q <= mode;
			cmd_key_q  <= record_key;
			cmd_p1_q   <= first_payload;
			cmd_p2_q   <= second_payload;
			cmd_rpos_q <= read_position;
			res_ok_q   <= add_ok;
			res_fpos_q <= '0;
			res_rec_q  <= '0;
		end
		if (scan_hit) begin
			res_ok_q <= 1'b1;
			if (cmd_mode_q == MODE_SEARCH) begin
				res_fpos_q <= hit_w[RPOS_W-1:0];
			end
		end
		if ((state_q == ST_READ) && rpos_ok) begin
			res_ok_q  <= 1'b1;
			res_rec_q <= mem_rd_data;
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_ok_q   <= res_ok_q;
			out_fpos_q <= res_fpos_q;
			out_rec_q  <= res_rec_q;
			out_cnt_q  <= cnt_w[RPOS_W-1:0];
		end
	end

	assign out_valid          = out_valid_q;
	assign success            = out_ok_q;
	assign found_position     = out_fpos_q;
	assign out_key            = out_rec_q.key;
	assign out_first_payload  = out_rec_q.p1;
	assign out_second_payload = out_rec_q.p2;
	assign entry_count        = out_cnt_q;

	// The table never holds more than SLOTS-1 records.
	`KRT_ASSERT_SAME(a_count_range, 1'b1, count_q <= CNT_MAX)
	// A compared scan entry lies inside positions 1..count.
	`KRT_ASSERT_SAME(a_scan_addr, chk_vld_s1 && (state_q == ST_SCAN), (addr_s1 != '0) && (addr_s1 <= count_x))
	// A shift never writes position 0.
	`KRT_ASSERT_SAME(a_shift_addr, sh_vld_s1 && (state_q == ST_SHIFT), sh_addr_s1 > {{PW{1'b0}}, 1'b1})
	// An add that finds room grows the count by one.
	`KRT_ASSERT_NEXT(a_add_count, add_ok, count_q == $past(count_q) + 1'b1)

endmodule
